// ===== src/rtsp_pkg.sv =====
// Shared types, constants and register codes for the touch-to-screen-point block.
package rtsp_pkg;

    localparam int SAMPLE_W   = 10;
    localparam int COORD_W    = 16;
    localparam int PRES_W     = 17;
    localparam int DIV_W      = 26;
    localparam int DSR_W      = 10;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] REG_ROTATION   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_CAL_MIN_X  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_CAL_MAX_X  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_CAL_MIN_Y  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_CAL_MAX_Y  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_PLATE_RES  = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD  = 3'd6;

    localparam logic [1:0] ROT_0   = 2'd0;
    localparam logic [1:0] ROT_180 = 2'd2;

    localparam logic [1:0]            RST_ROTATION  = 2'd0;
    localparam logic [SAMPLE_W-1:0]   RST_CAL_MIN_X = 10'd75;
    localparam logic [SAMPLE_W-1:0]   RST_CAL_MAX_X = 10'd650;
    localparam logic [SAMPLE_W-1:0]   RST_CAL_MIN_Y = 10'd280;
    localparam logic [SAMPLE_W-1:0]   RST_CAL_MAX_Y = 10'd935;
    localparam logic [15:0]           RST_PLATE_RES = 16'd0;
    localparam logic [15:0]           RST_THRESHOLD = 16'd200;

    localparam logic [SAMPLE_W:0]     FULL_SCALE    = 11'd1023;

    typedef struct packed {
        logic [SAMPLE_W:0] simple;
        logic              z1_zero;
        logic              num_zero;
        logic              neg;
    } press_side_t;

    typedef struct packed {
        logic span_zero;
        logic neg;
    } axis_side_t;

endpackage

// ===== src/rtsp_front.sv =====
// Front pipeline: sample inversion, axis selection, differences and products.
module rtsp_front #(
    parameter int SHORT_SIDE = 240,
    parameter int LONG_SIDE  = 320,
    parameter int EXT_W      = 9
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             in_valid,
    input  logic [rtsp_pkg::SAMPLE_W-1:0]    x_sample,
    input  logic [rtsp_pkg::SAMPLE_W-1:0]    y_sample,
    input  logic [rtsp_pkg::SAMPLE_W-1:0]    z1_sample,
    input  logic [rtsp_pkg::SAMPLE_W-1:0]    z2_sample,
    input  logic [1:0]                       rotation,
    input  logic [rtsp_pkg::SAMPLE_W-1:0]    cal_min_x,
    input  logic [rtsp_pkg::SAMPLE_W-1:0]    cal_max_x,
    input  logic [rtsp_pkg::SAMPLE_W-1:0]    cal_min_y,
    input  logic [rtsp_pkg::SAMPLE_W-1:0]    cal_max_y,
    input  logic [15:0]                      plate_res,
    output logic                             out_valid,
    output logic [rtsp_pkg::DIV_W-1:0]       p_dividend,
    output logic [rtsp_pkg::DSR_W-1:0]       p_divisor,
    output rtsp_pkg::press_side_t            p_side,
    output logic [rtsp_pkg::DIV_W-1:0]       x_dividend,
    output logic [rtsp_pkg::DSR_W-1:0]       x_divisor,
    output rtsp_pkg::axis_side_t             x_side,
    output logic [rtsp_pkg::DIV_W-1:0]       y_dividend,
    output logic [rtsp_pkg::DSR_W-1:0]       y_divisor,
    output rtsp_pkg::axis_side_t             y_side
);
    import rtsp_pkg::*;

    localparam int PROD_W = SAMPLE_W + EXT_W;
    localparam logic [EXT_W-1:0] EXT_SHORT = EXT_W'(SHORT_SIDE);
    localparam logic [EXT_W-1:0] EXT_LONG  = EXT_W'(LONG_SIDE);

    // stage 1
    logic                  s1_valid_reg;
    logic [SAMPLE_W-1:0]   s1_xi_reg, s1_z1_reg;
    logic [SAMPLE_W:0]     s1_dz_reg, s1_simple_reg;
    logic [SAMPLE_W:0]     s1_dx_reg, s1_spx_reg, s1_dy_reg, s1_spy_reg;
    logic [EXT_W-1:0]      s1_extx_reg, s1_exty_reg;

    logic [SAMPLE_W-1:0]   xi, yi, vx, vy, lox, hix, loy, hiy;
    logic                  landscape;

    always_comb
    begin
        xi        = ~x_sample;
        yi        = ~y_sample;
        landscape = (rotation == ROT_0) || (rotation == ROT_180);
        vx  = landscape ? yi : xi;
        lox = landscape ? cal_min_y : cal_min_x;
        hix = landscape ? cal_max_y : cal_max_x;
        vy  = landscape ? xi : yi;
        loy = landscape ? cal_min_x : cal_min_y;
        hiy = landscape ? cal_max_x : cal_max_y;
    end

    always_ff @(posedge clk)
    begin
        s1_xi_reg     <= xi;
        s1_z1_reg     <= z1_sample;
        s1_dz_reg     <= {1'b0, z2_sample} - {1'b0, z1_sample};
        s1_simple_reg <= {1'b0, z1_sample} + FULL_SCALE - {1'b0, z2_sample};
        s1_dx_reg     <= {1'b0, vx} - {1'b0, lox};
        s1_spx_reg    <= {1'b0, hix} - {1'b0, lox};
        s1_dy_reg     <= {1'b0, vy} - {1'b0, loy};
        s1_spy_reg    <= {1'b0, hiy} - {1'b0, loy};
        s1_extx_reg   <= landscape ? EXT_LONG : EXT_SHORT;
        s1_exty_reg   <= landscape ? EXT_SHORT : EXT_LONG;
    end

    // stage 2
    logic                  s2_valid_reg;
    logic [2*SAMPLE_W-1:0] s2_pm_reg;
    logic [SAMPLE_W-1:0]   s2_z1_reg;
    logic [SAMPLE_W:0]     s2_simple_reg;
    logic                  s2_pneg_reg, s2_pzero_reg;
    logic [PROD_W-1:0]     s2_xprod_reg, s2_yprod_reg;
    logic [SAMPLE_W-1:0]   s2_xspan_reg, s2_yspan_reg;
    logic                  s2_xneg_reg, s2_yneg_reg, s2_xsz_reg, s2_ysz_reg;

    logic [SAMPLE_W:0]     dz_neg, dx_neg, dy_neg, spx_neg, spy_neg;
    logic [SAMPLE_W-1:0]   dz_mag, dx_mag, dy_mag, spx_mag, spy_mag;

    always_comb
    begin
        dz_neg  = 11'd0 - s1_dz_reg;
        dx_neg  = 11'd0 - s1_dx_reg;
        dy_neg  = 11'd0 - s1_dy_reg;
        spx_neg = 11'd0 - s1_spx_reg;
        spy_neg = 11'd0 - s1_spy_reg;
        dz_mag  = s1_dz_reg[SAMPLE_W]  ? dz_neg[SAMPLE_W-1:0]  : s1_dz_reg[SAMPLE_W-1:0];
        dx_mag  = s1_dx_reg[SAMPLE_W]  ? dx_neg[SAMPLE_W-1:0]  : s1_dx_reg[SAMPLE_W-1:0];
        dy_mag  = s1_dy_reg[SAMPLE_W]  ? dy_neg[SAMPLE_W-1:0]  : s1_dy_reg[SAMPLE_W-1:0];
        spx_mag = s1_spx_reg[SAMPLE_W] ? spx_neg[SAMPLE_W-1:0] : s1_spx_reg[SAMPLE_W-1:0];
        spy_mag = s1_spy_reg[SAMPLE_W] ? spy_neg[SAMPLE_W-1:0] : s1_spy_reg[SAMPLE_W-1:0];
    end

    always_ff @(posedge clk)
    begin
        s2_pm_reg     <= dz_mag * s1_xi_reg;
        s2_pneg_reg   <= s1_dz_reg[SAMPLE_W];
        s2_pzero_reg  <= (dz_mag == '0) || (s1_xi_reg == '0);
        s2_z1_reg     <= s1_z1_reg;
        s2_simple_reg <= s1_simple_reg;
        s2_xprod_reg  <= dx_mag * s1_extx_reg;
        s2_yprod_reg  <= dy_mag * s1_exty_reg;
        s2_xspan_reg  <= spx_mag;
        s2_yspan_reg  <= spy_mag;
        s2_xneg_reg   <= s1_dx_reg[SAMPLE_W] ^ s1_spx_reg[SAMPLE_W];
        s2_yneg_reg   <= s1_dy_reg[SAMPLE_W] ^ s1_spy_reg[SAMPLE_W];
        s2_xsz_reg    <= (s1_spx_reg == '0);
        s2_ysz_reg    <= (s1_spy_reg == '0);
    end

    // stage 3
    logic                  s3_valid_reg;
    logic [2*SAMPLE_W+15:0] s3_num_reg;
    logic [SAMPLE_W-1:0]   s3_z1_reg;
    press_side_t           s3_pside_reg;
    logic [PROD_W-1:0]     s3_xprod_reg, s3_yprod_reg;
    logic [SAMPLE_W-1:0]   s3_xspan_reg, s3_yspan_reg;
    axis_side_t            s3_xside_reg, s3_yside_reg;

    always_ff @(posedge clk)
    begin
        s3_num_reg            <= s2_pm_reg * plate_res;
        s3_z1_reg             <= s2_z1_reg;
        s3_pside_reg.simple   <= s2_simple_reg;
        s3_pside_reg.z1_zero  <= (s2_z1_reg == '0);
        s3_pside_reg.num_zero <= s2_pzero_reg;
        s3_pside_reg.neg      <= s2_pneg_reg;
        s3_xprod_reg          <= s2_xprod_reg;
        s3_yprod_reg          <= s2_yprod_reg;
        s3_xspan_reg          <= s2_xspan_reg;
        s3_yspan_reg          <= s2_yspan_reg;
        s3_xside_reg          <= '{span_zero: s2_xsz_reg, neg: s2_xneg_reg};
        s3_yside_reg          <= '{span_zero: s2_ysz_reg, neg: s2_yneg_reg};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= in_valid;
            s2_valid_reg <= s1_valid_reg;
            s3_valid_reg <= s2_valid_reg;
        end
    end

    // |num| / (z1 * 1024) == (|num| >> 10) / z1
    assign out_valid  = s3_valid_reg;
    assign p_dividend = s3_num_reg[2*SAMPLE_W+15:10];
    assign p_divisor  = s3_z1_reg;
    assign p_side     = s3_pside_reg;
    assign x_dividend = DIV_W'(s3_xprod_reg);
    assign x_divisor  = s3_xspan_reg;
    assign x_side     = s3_xside_reg;
    assign y_dividend = DIV_W'(s3_yprod_reg);
    assign y_divisor  = s3_yspan_reg;
    assign y_side     = s3_yside_reg;

endmodule

// ===== src/rtsp_div.sv =====
// Pipelined restoring divider, one quotient bit per stage, with sideband.
module rtsp_div #(
    parameter int N      = 26,
    parameter int D      = 10,
    parameter int SIDE_W = 2
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              valid_in,
    input  logic [N-1:0]      dividend,
    input  logic [D-1:0]      divisor,
    input  logic [SIDE_W-1:0] side_in,
    output logic              valid_out,
    output logic [N-1:0]      quotient,
    output logic [SIDE_W-1:0] side_out
);
    logic              valid_reg [0:N-1];
    logic [N-1:0]      work_reg  [0:N-1];
    logic [D-1:0]      rem_reg   [0:N-1];
    logic [D-1:0]      dsr_reg   [0:N-1];
    logic [SIDE_W-1:0] side_reg  [0:N-1];

    for (genvar k = 0; k < N; k++)
    begin : g_stage
        logic              valid_cur;
        logic [N-1:0]      work_cur, work_next;
        logic [D-1:0]      rem_cur, rem_next, dsr_cur;
        logic [SIDE_W-1:0] side_cur;
        logic [D:0]        trial, diff;
        logic              fits;

        if (k == 0)
        begin : g_first
            assign valid_cur = valid_in;
            assign work_cur  = dividend;
            assign rem_cur   = '0;
            assign dsr_cur   = divisor;
            assign side_cur  = side_in;
        end
        else
        begin : g_next
            assign valid_cur = valid_reg[k-1];
            assign work_cur  = work_reg[k-1];
            assign rem_cur   = rem_reg[k-1];
            assign dsr_cur   = dsr_reg[k-1];
            assign side_cur  = side_reg[k-1];
        end

        always_comb
        begin
            trial     = {rem_cur, work_cur[N-1]};
            diff      = trial - {1'b0, dsr_cur};
            fits      = (trial >= {1'b0, dsr_cur});
            rem_next  = fits ? diff[D-1:0] : trial[D-1:0];
            work_next = {work_cur[N-2:0], fits};
        end

        always_ff @(posedge clk)
        begin
            work_reg[k] <= work_next;
            rem_reg[k]  <= rem_next;
            dsr_reg[k]  <= dsr_cur;
            side_reg[k] <= side_cur;
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                valid_reg[k] <= 1'b0;
            end
            else
            begin
                valid_reg[k] <= valid_cur;
            end
        end
    end

    assign valid_out = valid_reg[N-1];
    assign quotient  = work_reg[N-1];
    assign side_out  = side_reg[N-1];

endmodule

// ===== src/rtsp_back.sv =====
// Back end: sign restore, saturation, threshold compare and result register.
module rtsp_back (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             in_valid,
    input  logic [rtsp_pkg::DIV_W-1:0]       p_quot,
    input  rtsp_pkg::press_side_t            p_side,
    input  logic [rtsp_pkg::DIV_W-1:0]       x_quot,
    input  rtsp_pkg::axis_side_t             x_side,
    input  logic [rtsp_pkg::DIV_W-1:0]       y_quot,
    input  rtsp_pkg::axis_side_t             y_side,
    input  logic                             plate_zero,
    input  logic [15:0]                      threshold,
    output logic                             done,
    output logic signed [rtsp_pkg::COORD_W-1:0] screen_x,
    output logic signed [rtsp_pkg::COORD_W-1:0] screen_y,
    output logic signed [rtsp_pkg::PRES_W-1:0]  pressure,
    output logic                             pressed
);
    import rtsp_pkg::*;

    localparam logic [DIV_W-1:0] C_LIM_POS = DIV_W'(32767);
    localparam logic [DIV_W-1:0] C_LIM_NEG = DIV_W'(32768);
    localparam logic [DIV_W-1:0] P_LIM_POS = DIV_W'(65535);
    localparam logic [DIV_W-1:0] P_LIM_NEG = DIV_W'(65536);

    function automatic logic [COORD_W-1:0] sat_axis(input logic [DIV_W-1:0] q,
                                                    input axis_side_t s);
        logic [COORD_W-1:0] r;
        if (s.span_zero)
            r = '0;
        else if (s.neg)
            r = (q > C_LIM_NEG) ? 16'h8000 : 16'(16'd0 - q[COORD_W-1:0]);
        else
            r = (q > C_LIM_POS) ? 16'h7FFF : q[COORD_W-1:0];
        return r;
    endfunction

    logic                done_reg;
    logic [COORD_W-1:0]  sx_reg, sy_reg;
    logic [PRES_W-1:0]   pres_reg;
    logic                pressed_reg;
    logic [PRES_W-1:0]   pres_next;

    always_comb
    begin
        if (plate_zero)
            pres_next = PRES_W'(p_side.simple);
        else if (p_side.z1_zero)
            pres_next = p_side.num_zero ? '0 : 17'h0FFFF;
        else if (p_side.neg)
            pres_next = (p_quot > P_LIM_NEG) ? 17'h10000 : 17'(17'd0 - p_quot[PRES_W-1:0]);
        else
            pres_next = (p_quot > P_LIM_POS) ? 17'h0FFFF : p_quot[PRES_W-1:0];
    end

    always_ff @(posedge clk)
    begin
        sx_reg      <= sat_axis(x_quot, x_side);
        sy_reg      <= sat_axis(y_quot, y_side);
        pres_reg    <= pres_next;
        pressed_reg <= $signed({pres_next[PRES_W-1], pres_next}) > $signed({2'b00, threshold});
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= in_valid;
        end
    end

    assign done     = done_reg;
    assign screen_x = $signed(sx_reg);
    assign screen_y = $signed(sy_reg);
    assign pressure = $signed(pres_reg);
    assign pressed  = pressed_reg;

endmodule

// ===== src/resistive_touch_to_screen_point_top.sv =====
// Top level of the resistive touch to screen point block.
//
// Input channel: a word of four 10-bit samples (x_sample, y_sample, z1_sample,
// z2_sample) is taken at each rising edge with start high and busy low. busy is
// always low, so a new word may be presented in every cycle.
// Result channel: done is high for one cycle with screen_x, screen_y, pressure
// and pressed valid; the receiver cannot stall, so none is needed here.
// Pipeline: each word passes three front stages, a 26-stage one-bit-per-stage
// divider, and the output register. Throughput: one word per cycle.
// Configuration: cfg_write, cfg_index and cfg_data write one register per edge;
// write only while no word is in flight.
// Reset: rst_n clears the pipeline valid bits and loads the register defaults;
// words in flight are dropped.
module resistive_touch_to_screen_point_top #(
    parameter int PANEL_SHORT_SIDE = 240,
    parameter int PANEL_LONG_SIDE  = 320
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              start,
    output logic                              busy,
    input  logic [rtsp_pkg::SAMPLE_W-1:0]     x_sample,
    input  logic [rtsp_pkg::SAMPLE_W-1:0]     y_sample,
    input  logic [rtsp_pkg::SAMPLE_W-1:0]     z1_sample,
    input  logic [rtsp_pkg::SAMPLE_W-1:0]     z2_sample,
    output logic                              done,
    output logic signed [rtsp_pkg::COORD_W-1:0] screen_x,
    output logic signed [rtsp_pkg::COORD_W-1:0] screen_y,
    output logic signed [rtsp_pkg::PRES_W-1:0]  pressure,
    output logic                              pressed,
    input  logic                              cfg_write,
    input  logic [rtsp_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [rtsp_pkg::CFG_DATA_W-1:0]   cfg_data
);
    import rtsp_pkg::*;

    localparam int EXT_MAX = (PANEL_SHORT_SIDE > PANEL_LONG_SIDE) ?
                             PANEL_SHORT_SIDE : PANEL_LONG_SIDE;
    localparam int EXT_W   = $clog2(EXT_MAX + 1);

    logic [1:0]          rotation_reg;
    logic [SAMPLE_W-1:0] cal_min_x_reg, cal_max_x_reg, cal_min_y_reg, cal_max_y_reg;
    logic [15:0]         plate_res_reg, threshold_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rotation_reg  <= RST_ROTATION;
            cal_min_x_reg <= RST_CAL_MIN_X;
            cal_max_x_reg <= RST_CAL_MAX_X;
            cal_min_y_reg <= RST_CAL_MIN_Y;
            cal_max_y_reg <= RST_CAL_MAX_Y;
            plate_res_reg <= RST_PLATE_RES;
            threshold_reg <= RST_THRESHOLD;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                REG_ROTATION:  rotation_reg  <= cfg_data[1:0];
                REG_CAL_MIN_X: cal_min_x_reg <= cfg_data[SAMPLE_W-1:0];
                REG_CAL_MAX_X: cal_max_x_reg <= cfg_data[SAMPLE_W-1:0];
                REG_CAL_MIN_Y: cal_min_y_reg <= cfg_data[SAMPLE_W-1:0];
                REG_CAL_MAX_Y: cal_max_y_reg <= cfg_data[SAMPLE_W-1:0];
                REG_PLATE_RES: plate_res_reg <= cfg_data;
                REG_THRESHOLD: threshold_reg <= cfg_data;
                default:       ;
            endcase
        end
    end

    logic                front_valid;
    logic [DIV_W-1:0]    p_dividend, x_dividend, y_dividend;
    logic [DSR_W-1:0]    p_divisor, x_divisor, y_divisor;
    press_side_t         p_side_in, p_side_out;
    axis_side_t          x_side_in, x_side_out, y_side_in, y_side_out;
    logic                div_valid;
    logic [DIV_W-1:0]    p_quot, x_quot, y_quot;

    assign busy = 1'b0;

    rtsp_front #(
        .SHORT_SIDE (PANEL_SHORT_SIDE),
        .LONG_SIDE  (PANEL_LONG_SIDE),
        .EXT_W      (EXT_W)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (start && !busy),
        .x_sample   (x_sample),
        .y_sample   (y_sample),
        .z1_sample  (z1_sample),
        .z2_sample  (z2_sample),
        .rotation   (rotation_reg),
        .cal_min_x  (cal_min_x_reg),
        .cal_max_x  (cal_max_x_reg),
        .cal_min_y  (cal_min_y_reg),
        .cal_max_y  (cal_max_y_reg),
        .plate_res  (plate_res_reg),
        .out_valid  (front_valid),
        .p_dividend (p_dividend),
        .p_divisor  (p_divisor),
        .p_side     (p_side_in),
        .x_dividend (x_dividend),
        .x_divisor  (x_divisor),
        .x_side     (x_side_in),
        .y_dividend (y_dividend),
        .y_divisor  (y_divisor),
        .y_side     (y_side_in)
    );

    rtsp_div #(
        .N      (DIV_W),
        .D      (DSR_W),
        .SIDE_W ($bits(press_side_t))
    ) u_div_p (
        .clk       (clk),
        .rst_n     (rst_n),
        .valid_in  (front_valid),
        .dividend  (p_dividend),
        .divisor   (p_divisor),
        .side_in   (p_side_in),
        .valid_out (div_valid),
        .quotient  (p_quot),
        .side_out  (p_side_out)
    );

    rtsp_div #(
        .N      (DIV_W),
        .D      (DSR_W),
        .SIDE_W ($bits(axis_side_t))
    ) u_div_x (
        .clk       (clk),
        .rst_n     (rst_n),
        .valid_in  (front_valid),
        .dividend  (x_dividend),
        .divisor   (x_divisor),
        .side_in   (x_side_in),
        .valid_out (),
        .quotient  (x_quot),
        .side_out  (x_side_out)
    );

    rtsp_div #(
        .N      (DIV_W),
        .D      (DSR_W),
        .SIDE_W ($bits(axis_side_t))
    ) u_div_y (
        .clk       (clk),
        .rst_n     (rst_n),
        .valid_in  (front_valid),
        .dividend  (y_dividend),
        .divisor   (y_divisor),
        .side_in   (y_side_in),
        .valid_out (),
        .quotient  (y_quot),
        .side_out  (y_side_out)
    );

    rtsp_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (div_valid),
        .p_quot     (p_quot),
        .p_side     (p_side_out),
        .x_quot     (x_quot),
        .x_side     (x_side_out),
        .y_quot     (y_quot),
        .y_side     (y_side_out),
        .plate_zero (plate_res_reg == '0),
        .threshold  (threshold_reg),
        .done       (done),
        .screen_x   (screen_x),
        .screen_y   (screen_y),
        .pressure   (pressure),
        .pressed    (pressed)
    );

endmodule

// ===== tb/rtsp_point_checker.sv =====
// Checker for the touch-to-screen-point block: predicts each result word and compares it.
`timescale 1ns / 100ps

module rtsp_point_checker #(
    parameter int PANEL_SHORT_SIDE = 240,
    parameter int PANEL_LONG_SIDE  = 320
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                start,
    input  logic                                busy,
    input  logic [rtsp_pkg::SAMPLE_W-1:0]       x_sample,
    input  logic [rtsp_pkg::SAMPLE_W-1:0]       y_sample,
    input  logic [rtsp_pkg::SAMPLE_W-1:0]       z1_sample,
    input  logic [rtsp_pkg::SAMPLE_W-1:0]       z2_sample,
    input  logic                                done,
    input  logic signed [rtsp_pkg::COORD_W-1:0] screen_x,
    input  logic signed [rtsp_pkg::COORD_W-1:0] screen_y,
    input  logic signed [rtsp_pkg::PRES_W-1:0]  pressure,
    input  logic                                pressed,
    input  logic                                cfg_write,
    input  logic [rtsp_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [rtsp_pkg::CFG_DATA_W-1:0]     cfg_data,
    output int                                  outstanding,
    output int                                  errors
);
    import rtsp_pkg::*;

    typedef struct packed {
        logic signed [COORD_W-1:0] sx;
        logic signed [COORD_W-1:0] sy;
        logic signed [PRES_W-1:0]  pres;
        logic                      touched;
    } screen_point_t;

    logic [1:0]          rot_q;
    logic [SAMPLE_W-1:0] min_x_q, max_x_q, min_y_q, max_y_q;
    logic [15:0]         plate_q, thresh_q;

    screen_point_t expected_points[$];
    screen_point_t want;

    initial begin
        errors = 0;
        outstanding = 0;
    end

    function automatic longint clamp_range(input longint v, input longint lo, input longint hi);
        if (v < lo)
            return lo;
        if (v > hi)
            return hi;
        return v;
    endfunction

    function automatic longint map_axis(input longint v, input longint lo, input longint hi,
                                        input longint extent);
        longint span;
        span = hi - lo;
        if (span == 0)
            return 0;
        return clamp_range((v - lo) * extent / span, -32768, 32767);
    endfunction

    function automatic screen_point_t predict_point(input logic [SAMPLE_W-1:0] xs,
                                                    input logic [SAMPLE_W-1:0] ys,
                                                    input logic [SAMPLE_W-1:0] z1s,
                                                    input logic [SAMPLE_W-1:0] z2s);
        longint xi, yi, z1, z2, num, pres, sx, sy;
        screen_point_t p;
        xi = 1023 - longint'(xs);
        yi = 1023 - longint'(ys);
        z1 = longint'(z1s);
        z2 = longint'(z2s);
        if (plate_q == 16'd0)
            pres = 1023 - (z2 - z1);
        else
        begin
            num = (z2 - z1) * xi * longint'(plate_q);
            if (z1 == 0)
                pres = (num == 0) ? 0 : 65535;
            else
                pres = num / (z1 * 1024);
        end
        pres = clamp_range(pres, -65536, 65535);
        if (rot_q == ROT_0 || rot_q == ROT_180)
        begin
            sx = map_axis(yi, longint'(min_y_q), longint'(max_y_q), PANEL_LONG_SIDE);
            sy = map_axis(xi, longint'(min_x_q), longint'(max_x_q), PANEL_SHORT_SIDE);
        end
        else
        begin
            sx = map_axis(xi, longint'(min_x_q), longint'(max_x_q), PANEL_SHORT_SIDE);
            sy = map_axis(yi, longint'(min_y_q), longint'(max_y_q), PANEL_LONG_SIDE);
        end
        p.sx      = sx[COORD_W-1:0];
        p.sy      = sy[COORD_W-1:0];
        p.pres    = pres[PRES_W-1:0];
        p.touched = (pres > longint'(thresh_q));
        return p;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rot_q    = RST_ROTATION;
            min_x_q  = RST_CAL_MIN_X;
            max_x_q  = RST_CAL_MAX_X;
            min_y_q  = RST_CAL_MIN_Y;
            max_y_q  = RST_CAL_MAX_Y;
            plate_q  = RST_PLATE_RES;
            thresh_q = RST_THRESHOLD;
            expected_points.delete();
        end
        else
        begin
            if (cfg_write)
            begin
                case (cfg_index)
                    REG_ROTATION:  rot_q    = cfg_data[1:0];
                    REG_CAL_MIN_X: min_x_q  = cfg_data[SAMPLE_W-1:0];
                    REG_CAL_MAX_X: max_x_q  = cfg_data[SAMPLE_W-1:0];
                    REG_CAL_MIN_Y: min_y_q  = cfg_data[SAMPLE_W-1:0];
                    REG_CAL_MAX_Y: max_y_q  = cfg_data[SAMPLE_W-1:0];
                    REG_PLATE_RES: plate_q  = cfg_data;
                    REG_THRESHOLD: thresh_q = cfg_data;
                    default: ;
                endcase
            end
            if (start && !busy)
                expected_points.push_back(predict_point(x_sample, y_sample, z1_sample,
                                                        z2_sample));
            if (done)
            begin
                if (expected_points.size() == 0)
                begin
                    $display("%0t: unexpected word: expected none, actual %0d %0d %0d %0d",
                             $time, screen_x, screen_y, pressure, pressed);
                    errors++;
                end
                else
                begin
                    want = expected_points.pop_front();
                    if (screen_x !== want.sx)
                    begin
                        $display("%0t: screen_x expected %0d actual %0d",
                                 $time, want.sx, screen_x);
                        errors++;
                    end
                    if (screen_y !== want.sy)
                    begin
                        $display("%0t: screen_y expected %0d actual %0d",
                                 $time, want.sy, screen_y);
                        errors++;
                    end
                    if (pressure !== want.pres)
                    begin
                        $display("%0t: pressure expected %0d actual %0d",
                                 $time, want.pres, pressure);
                        errors++;
                    end
                    if (pressed !== want.touched)
                    begin
                        $display("%0t: pressed expected %0d actual %0d",
                                 $time, want.touched, pressed);
                        errors++;
                    end
                end
            end
        end
        outstanding = expected_points.size();
    end

endmodule

// ===== tb/resistive_touch_to_screen_point_top_test.sv =====
// Top of the touch-to-screen-point testbench: clock, reset, stimulus and verdict.
`timescale 1ns / 100ps

module resistive_touch_to_screen_point_top_test;
    import rtsp_pkg::*;

    localparam int SHORT_SIDE = 240;
    localparam int LONG_SIDE  = 320;

    localparam logic [1:0]           ROT_90        = 2'd1;
    localparam logic [1:0]           ROT_270       = 2'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_SPARE = 3'd7;

    logic                        clk;
    logic                        rst_n;
    logic                        start;
    logic                        busy;
    logic                        busy_seen;
    logic [SAMPLE_W-1:0]         x_sample, y_sample, z1_sample, z2_sample;
    logic                        done;
    logic signed [COORD_W-1:0]   screen_x, screen_y;
    logic signed [PRES_W-1:0]    pressure;
    logic                        pressed;
    logic                        cfg_write;
    logic [CFG_IDX_W-1:0]        cfg_index;
    logic [CFG_DATA_W-1:0]       cfg_data;
    int                          outstanding;
    int                          errors;
    bit                          idle_on;

    resistive_touch_to_screen_point_top #(
        .PANEL_SHORT_SIDE(SHORT_SIDE),
        .PANEL_LONG_SIDE (LONG_SIDE)
    ) dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (start),
        .busy     (busy),
        .x_sample (x_sample),
        .y_sample (y_sample),
        .z1_sample(z1_sample),
        .z2_sample(z2_sample),
        .done     (done),
        .screen_x (screen_x),
        .screen_y (screen_y),
        .pressure (pressure),
        .pressed  (pressed),
        .cfg_write(cfg_write),
        .cfg_index(cfg_index),
        .cfg_data (cfg_data)
    );

    rtsp_point_checker #(
        .PANEL_SHORT_SIDE(SHORT_SIDE),
        .PANEL_LONG_SIDE (LONG_SIDE)
    ) point_check (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .busy       (busy),
        .x_sample   (x_sample),
        .y_sample   (y_sample),
        .z1_sample  (z1_sample),
        .z2_sample  (z2_sample),
        .done       (done),
        .screen_x   (screen_x),
        .screen_y   (screen_y),
        .pressure   (pressure),
        .pressed    (pressed),
        .cfg_write  (cfg_write),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .outstanding(outstanding),
        .errors     (errors)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #2000000;
        $display("resistive_touch_to_screen_point_top regression: fail");
        $finish;
    end

    // busy only moves at rising edges; the mid-cycle copy is the value seen at the next edge
    always @(negedge clk)
        busy_seen <= busy;

    task automatic send_word(input logic [SAMPLE_W-1:0] xs, input logic [SAMPLE_W-1:0] ys,
                             input logic [SAMPLE_W-1:0] z1s, input logic [SAMPLE_W-1:0] z2s);
        while (idle_on && $urandom_range(99) < 36)
        begin
            start <= 1'b0;
            @(posedge clk);
        end
        start     <= 1'b1;
        x_sample  <= xs;
        y_sample  <= ys;
        z1_sample <= z1s;
        z2_sample <= z2s;
        @(posedge clk);
        while (busy_seen)
            @(posedge clk);
    endtask

    function automatic logic [SAMPLE_W-1:0] pick_sample();
        case ($urandom_range(7))
            0:       return 10'd0;
            1:       return 10'd1023;
            default: return 10'($urandom_range(1023));
        endcase
    endfunction

    task automatic send_random_word();
        logic [SAMPLE_W-1:0] xs, ys, z1s, z2s;
        xs  = pick_sample();
        ys  = pick_sample();
        z1s = pick_sample();
        z2s = ($urandom_range(9) == 0) ? z1s : pick_sample();
        send_word(xs, ys, z1s, z2s);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] d);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= d;
        @(posedge clk);
    endtask

    // narrow registers get random upper bits; the block keeps only the low ones
    task automatic program_regs(input logic [1:0] rot,
                                input logic [SAMPLE_W-1:0] min_x, input logic [SAMPLE_W-1:0] max_x,
                                input logic [SAMPLE_W-1:0] min_y, input logic [SAMPLE_W-1:0] max_y,
                                input logic [15:0] plate, input logic [15:0] thresh);
        logic [15:0] junk;
        junk = 16'($urandom);
        write_reg(REG_ROTATION,  {junk[15:2], rot});
        write_reg(REG_CAL_MIN_X, {junk[15:10], min_x});
        junk = 16'($urandom);
        write_reg(REG_CAL_MAX_X, {junk[15:10], max_x});
        write_reg(REG_CAL_MIN_Y, {junk[9:4], min_y});
        junk = 16'($urandom);
        write_reg(REG_CAL_MAX_Y, {junk[15:10], max_y});
        write_reg(REG_PLATE_RES, plate);
        write_reg(REG_THRESHOLD, thresh);
        write_reg(CFG_IDX_SPARE, 16'($urandom));
        cfg_write <= 1'b0;
    endtask

    task automatic settle();
        start <= 1'b0;
        @(negedge clk);
        while (outstanding != 0)
            @(negedge clk);
        repeat (32) @(negedge clk);
        @(posedge clk);
    endtask

    function automatic logic [15:0] pick_plate();
        case ($urandom_range(3))
            0:       return 16'd0;
            1:       return 16'hFFFF;
            2:       return 16'($urandom_range(500, 1));
            default: return 16'($urandom_range(65535));
        endcase
    endfunction

    initial
    begin
        rst_n     = 1'b0;
        start     = 1'b0;
        x_sample  = '0;
        y_sample  = '0;
        z1_sample = '0;
        z2_sample = '0;
        cfg_write = 1'b0;
        cfg_index = '0;
        cfg_data  = '0;
        idle_on   = 1'b1;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        // reset calibration: extremes, calibration edges, bit patterns
        send_word(10'd0,    10'd0,    10'd0,    10'd0);
        send_word(10'd1023, 10'd1023, 10'd1023, 10'd1023);
        send_word(10'd0,    10'd1023, 10'd0,    10'd1023);
        send_word(10'd1023, 10'd0,    10'd1023, 10'd0);
        send_word(10'd948,  10'd743,  10'd100,  10'd300);
        send_word(10'd373,  10'd88,   10'd300,  10'd100);
        send_word(10'h2AA,  10'h155,  10'h2AA,  10'h155);
        send_word(10'h155,  10'h2AA,  10'h155,  10'h2AA);
        send_word(10'd512,  10'd512,  10'd0,    10'd823);
        send_word(10'd512,  10'd512,  10'd0,    10'd822);
        settle();

        // plate resistance set: zero z1, zero numerator, negative and saturated pressure
        program_regs(ROT_0, RST_CAL_MIN_X, RST_CAL_MAX_X, RST_CAL_MIN_Y, RST_CAL_MAX_Y,
                     16'hFFFF, 16'd0);
        send_word(10'd0,    10'd0,    10'd0,    10'd0);
        send_word(10'd0,    10'd500,  10'd0,    10'd5);
        send_word(10'd1023, 10'd500,  10'd0,    10'd700);
        send_word(10'd0,    10'd0,    10'd1023, 10'd0);
        send_word(10'd0,    10'd1023, 10'd1,    10'd1023);
        send_word(10'd0,    10'd300,  10'd1,    10'd0);
        send_word(10'd400,  10'd400,  10'd200,  10'd200);
        send_word(10'd1,    10'd1022, 10'd1022, 10'd1);
        send_word(10'd700,  10'd100,  10'd513,  10'd900);
        settle();

        for (int ph = 0; ph < 10; ph++)
        begin
            case (ph)
                0: program_regs(ROT_90, 10'd75, 10'd650, 10'd280, 10'd935, 16'd0, 16'd200);
                1: program_regs(ROT_180, 10'd0, 10'd1023, 10'd0, 10'd1023, 16'hFFFF, 16'd0);
                2: program_regs(ROT_270, 10'd1023, 10'd0, 10'd1023, 10'd0, 16'd1, 16'hFFFF);
                3: program_regs(ROT_0, 10'd500, 10'd500, 10'd300, 10'd300, 16'd4000, 16'd1000);
                4: program_regs(ROT_90, 10'd0, 10'd1, 10'd1022, 10'd1023, 16'hFFFF, 16'hFFFF);
                5: program_regs(ROT_270, 10'd1023, 10'd1023, 10'd0, 10'd0, 16'd0, 16'd2046);
                default:
                    program_regs(2'($urandom_range(3)), pick_sample(), pick_sample(),
                                 pick_sample(), pick_sample(), pick_plate(),
                                 ($urandom_range(1) != 0) ? 16'($urandom_range(65535))
                                                          : 16'($urandom_range(2100)));
            endcase
            idle_on = (ph == 1) ? 1'b0 : ($urandom_range(3) != 0);
            repeat (175) send_random_word();
            settle();
        end

        if (errors == 0)
            $display("resistive_touch_to_screen_point_top regression: pass");
        else
            $display("resistive_touch_to_screen_point_top regression: fail");
        $finish;
    end

endmodule

// ===== files.f =====
src/rtsp_pkg.sv
src/rtsp_front.sv
src/rtsp_div.sv
src/rtsp_back.sv
src/resistive_touch_to_screen_point_top.sv
tb/rtsp_point_checker.sv
tb/resistive_touch_to_screen_point_top_test.sv
